// ===== hw/rtl/zvc_pkg.sv =====
// ----------------------------------------------------------------------------
// zvc_pkg
// Shared types, codes and zigzag helpers for the zigzag varint codec.
// ----------------------------------------------------------------------------
package zvc_pkg;

    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int GROUP_W = 7;
    localparam int COUNT_W = 4;

    localparam logic [GROUP_W-1:0] PAYLOAD_MASK = 7'h7F;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 4'd15;
    // group index that lands on bit 63; only payload bit 0 fits there
    localparam logic [COUNT_W-1:0] TOP_GROUP    = 4'd9;

    // item opcodes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_ENC
    } t_state;

    // completed decode result handed from the accumulator to the top level
    typedef struct packed {
        logic                      done;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
        logic                      truncated;
        logic                      overflow;
    } t_dec_res;

    function automatic logic [VALUE_W-1:0] zz_encode(input logic [VALUE_W-1:0] v);
        zz_encode = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
    endfunction

    function automatic logic [VALUE_W-1:0] zz_decode(input logic [VALUE_W-1:0] a);
        zz_decode = {1'b0, a[VALUE_W-1:1]} ^ {VALUE_W{a[0]}};
    endfunction

endpackage

// ===== hw/rtl/zvc_in_if.sv =====
// ----------------------------------------------------------------------------
// zvc_in_if
// Input channel of the codec: one encode value or one decode byte per item.
// ----------------------------------------------------------------------------
interface zvc_in_if;
    import zvc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [VALUE_W-1:0] value_in;
    logic [BYTE_W-1:0]         byte_in;
    logic                      end_of_data;

    modport source (output valid, output op, output value_in, output byte_in,
                    output end_of_data, input ready);
    modport sink   (input valid, input op, input value_in, input byte_in,
                    input end_of_data, output ready);
endinterface

// ===== hw/rtl/zvc_out_if.sv =====
// ----------------------------------------------------------------------------
// zvc_out_if
// Output channel of the codec: one encoded byte or one decoded value per item.
// ----------------------------------------------------------------------------
interface zvc_out_if;
    import zvc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [BYTE_W-1:0]         byte_out;
    logic                      last;
    logic signed [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0]        bytes_read;
    logic                      truncated;
    logic                      overflow;

    modport source (output valid, output kind, output byte_out, output last,
                    output value_out, output bytes_read, output truncated,
                    output overflow, input ready);
    modport sink   (input valid, input kind, input byte_out, input last,
                    input value_out, input bytes_read, input truncated,
                    input overflow, output ready);
endinterface

// ===== hw/rtl/zvc_dec_acc.sv =====
// ----------------------------------------------------------------------------
// zvc_dec_acc
// Varint decode accumulator: places one 7-bit group per byte and reports
// the zigzag-decoded value when a byte ends the varint or the data ends.
// ----------------------------------------------------------------------------
module zvc_dec_acc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [zvc_pkg::BYTE_W-1:0]     i_byte,
    input  logic                           i_eod,
    output zvc_pkg::t_dec_res              o_res
);
    import zvc_pkg::*;

    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_ovf, n_ovf;

    logic [GROUP_W-1:0] payload;
    logic               cont;
    logic [5:0]         shamt;
    logic [VALUE_W-1:0] acc_add;
    logic [COUNT_W-1:0] cnt_add;
    logic               ovf_add;

    always_comb begin
        payload = i_byte[GROUP_W-1:0] & PAYLOAD_MASK;
        cont    = i_byte[BYTE_W-1];
        shamt   = 6'(r_cnt) * 6'(GROUP_W);
        acc_add = r_acc;
        ovf_add = r_ovf;
        priority if (r_cnt < TOP_GROUP) begin
            acc_add = r_acc | (VALUE_W'(payload) << shamt);
        end else if (r_cnt == TOP_GROUP) begin
            acc_add = r_acc | {payload[0], {(VALUE_W-1){1'b0}}};
            if (payload[GROUP_W-1:1] != '0) begin
                ovf_add = 1'b1;
            end
        end else begin
            // past the tenth byte: drop the payload
            ovf_add = 1'b1;
        end
        cnt_add = (r_cnt < COUNT_MAX) ? r_cnt + 1'b1 : r_cnt;

        o_res.done      = i_step && (!cont || i_eod);
        o_res.value     = zz_decode(acc_add);
        o_res.count     = cnt_add;
        o_res.truncated = cont;
        o_res.overflow  = ovf_add;

        n_acc = r_acc;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (o_res.done) begin
            n_acc = '0;
            n_cnt = '0;
            n_ovf = 1'b0;
        end else if (i_step) begin
            n_acc = acc_add;
            n_cnt = cnt_add;
            n_ovf = ovf_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

endmodule

// ===== hw/rtl/zigzag_varint_codec.sv =====
// ----------------------------------------------------------------------------
// zigzag_varint_codec
// Signed 64-bit zigzag plus base-128 varint encoder and byte-wise decoder.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items with op = encode (value_in) or op = decode (byte_in,
//   end_of_data). o_out carries results: kind = byte for encoded bytes,
//   kind = value for decoded values.
//   Encode: an item yields 1 to 10 bytes, low group first, one byte per
//   cycle while the receiver keeps up, from a single 7-bit group extractor;
//   the first byte is registered at the accept edge, and the input is not
//   ready until the last byte of the item has been registered.
//   Decode: one byte per cycle while the output register is free; a byte
//   that ends a varint (or carries end_of_data) places the value in the
//   output register at the accept edge.
//   The output register is the only buffer: a stalled receiver stops the
//   encode sequence and blocks new items until the pending result is taken.
//   Reset clears the output valid, the sequencer and the partial decode
//   value; an encode item leaves a partial decode untouched.
// ----------------------------------------------------------------------------
module zigzag_varint_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    zvc_in_if.sink     i_in,
    zvc_out_if.source  o_out
);
    import zvc_pkg::*;

    t_state r_state, n_state;

    logic [VALUE_W-1:0] r_zz, n_zz;
    logic [COUNT_W-1:0] r_pos, n_pos;

    logic                      r_out_valid, n_out_valid;
    logic                      r_kind, n_kind;
    logic [BYTE_W-1:0]         r_byte, n_byte;
    logic                      r_last, n_last;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [COUNT_W-1:0]        r_nread, n_nread;
    logic                      r_trunc, n_trunc;
    logic                      r_ovf, n_ovf;

    logic               out_free;
    logic               in_ready;
    logic               in_take;
    logic               dec_step;
    logic               enc_emit;
    logic [VALUE_W-1:0] grp_src;
    logic               grp_more;
    logic [COUNT_W-1:0] grp_pos;
    t_dec_res           dec_res;

    zvc_dec_acc u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (dec_step),
        .i_byte  (i_in.byte_in),
        .i_eod   (i_in.end_of_data),
        .o_res   (dec_res)
    );

    always_comb begin
        out_free = !r_out_valid || o_out.ready;
        in_ready = (r_state == ST_IDLE) && out_free;
        in_take  = i_in.valid && in_ready;
        dec_step = in_take && (i_in.op == OP_DECODE);

        // group extractor, fed from the new value or the remaining word
        grp_src  = (r_state == ST_IDLE) ? zz_encode(i_in.value_in) : r_zz;
        grp_pos  = (r_state == ST_IDLE) ? COUNT_W'(1) : r_pos;
        grp_more = |grp_src[VALUE_W-1:GROUP_W];

        enc_emit = 1'b0;
        n_state  = r_state;
        n_zz     = r_zz;
        n_pos    = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                enc_emit = in_take && (i_in.op == OP_ENCODE);
            end
            ST_ENC: begin
                enc_emit = out_free;
            end
            default: begin
                enc_emit = 1'b0;
            end
        endcase
        if (enc_emit) begin
            n_zz    = grp_src >> GROUP_W;
            n_pos   = grp_pos + 1'b1;
            n_state = grp_more ? ST_ENC : ST_IDLE;
        end

        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_last      = r_last;
        n_value     = r_value;
        n_nread     = r_nread;
        n_trunc     = r_trunc;
        n_ovf       = r_ovf;
        if (enc_emit) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_BYTE;
            n_byte      = {grp_more, grp_src[GROUP_W-1:0] & PAYLOAD_MASK};
            n_last      = !grp_more;
            n_value     = '0;
            n_nread     = grp_pos;
            n_trunc     = 1'b0;
            n_ovf       = 1'b0;
        end else if (dec_res.done) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_VALUE;
            n_byte      = '0;
            n_last      = 1'b1;
            n_value     = dec_res.value;
            n_nread     = dec_res.count;
            n_trunc     = dec_res.truncated;
            n_ovf       = dec_res.overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zz    <= n_zz;
        r_pos   <= n_pos;
        r_kind  <= n_kind;
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_value <= n_value;
        r_nread <= n_nread;
        r_trunc <= n_trunc;
        r_ovf   <= n_ovf;
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_kind;
    assign o_out.byte_out   = r_byte;
    assign o_out.last       = r_last;
    assign o_out.value_out  = r_value;
    assign o_out.bytes_read = r_nread;
    assign o_out.truncated  = r_trunc;
    assign o_out.overflow   = r_ovf;

endmodule

// ===== hw/rtl/zvc_checker.sv =====
// ----------------------------------------------------------------------------
// zvc_checker
// Port-level checks on the codec output channel, bound to the top level.
// ----------------------------------------------------------------------------
module zvc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_kind,
    input logic [zvc_pkg::BYTE_W-1:0]     i_byte_out,
    input logic                           i_last,
    input logic [zvc_pkg::COUNT_W-1:0]    i_bytes_read,
    input logic                           i_truncated
);
    import zvc_pkg::*;

    // hold the result while the receiver stalls
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_kind) && $stable(i_byte_out)
            && $stable(i_last) && $stable(i_bytes_read))
        else $error("output item changed while stalled");

    // continuation bit is set on every encoded byte but the last
    a_cont_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_BYTE) |-> (i_byte_out[BYTE_W-1] == !i_last))
        else $error("continuation bit disagrees with last");

    // a decoded value is always last and counts at least one byte
    a_value_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_VALUE) |->
            i_last && (i_bytes_read != '0) && (i_byte_out == '0))
        else $error("malformed decoded value item");

    // a taken non-final byte is followed at once by the next encoded byte
    a_enc_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_kind == KIND_BYTE) && !i_last |=>
            i_out_valid && (i_kind == KIND_BYTE) && !i_truncated
            && (i_bytes_read == $past(i_bytes_read) + 1'b1))
        else $error("encode sequence broken");

endmodule

bind zigzag_varint_codec zvc_checker u_zvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_kind       (o_out.kind),
    .i_byte_out   (o_out.byte_out),
    .i_last       (o_out.last),
    .i_bytes_read (o_out.bytes_read),
    .i_truncated  (o_out.truncated)
);
